/* src/framed_packet_parser_sum_add_check_defines.svh */
// assertion macros for the framed packet parser checker
// expects clk_i and rst_ni in the scope where the macros are used
`ifndef FRAMED_PACKET_PARSER_SUM_ADD_CHECK_DEFINES_SVH
`define FRAMED_PACKET_PARSER_SUM_ADD_CHECK_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define FPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/fpp_pkg.sv */
// shared types and constants of the framed packet parser
// no dependencies
`timescale 1ns / 1ps

package fpp_pkg;

  // frame format
  localparam logic [7:0] HeaderByte   = 8'hAA;
  localparam logic [7:0] LengthLimit  = 8'd250;
  localparam logic [7:0] OwnAddrRst   = 8'h11;
  localparam logic [7:0] BcastAddrRst = 8'hFF;

  // result queue between parser and output stage
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // configuration register index
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_OWN_ADDR   = 2'd0,
    CFG_BCAST_ADDR = 2'd1
  } cfg_idx_e;

  // parser phase
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_ADDR    = 3'd1,
    PH_CMD     = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_SUMCHK  = 3'd5,
    PH_ADDCHK  = 3'd6
  } phase_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SUM_ERR = 2'd1,
    ST_ADD_ERR = 2'd2
  } status_e;

  // token from the parser: payload byte, or frame end with the check values
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;      // payload byte, or received add-check byte
    logic [7:0] index;
    logic [7:0] addr;
    logic [7:0] cmd;
    logic [7:0] len;
    logic [7:0] sum_calc;
    logic [7:0] sum_rx;
    logic [7:0] add_calc;
  } tok_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

/* src/fpp_front.sv */
// front end: byte parser with on-the-fly running sums and address registers
// depends on fpp_pkg
`timescale 1ns / 1ps

module fpp_front
  import fpp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               byte_valid_i,
  input  logic [7:0]         rx_byte_i,
  output logic               tok_valid_o,
  output tok_t               tok_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] remain_q, remain_d;
  logic [7:0] pos_q, pos_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] add_q, add_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] len_q, len_d;
  logic [7:0] sumrx_q, sumrx_d;
  logic [7:0] own_q, bcast_q;
  logic [7:0] sum_acc, add_acc;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q   <= OwnAddrRst;
      bcast_q <= BcastAddrRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OWN_ADDR:   own_q   <= cfg_data_i;
        CFG_BCAST_ADDR: bcast_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // running sums including the current byte
  assign sum_acc = sum_q + rx_byte_i;
  assign add_acc = add_q + sum_acc;

  // parser state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      remain_q <= '0;
      pos_q    <= '0;
      sum_q    <= '0;
      add_q    <= '0;
      addr_q   <= '0;
      cmd_q    <= '0;
      len_q    <= '0;
      sumrx_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      remain_q <= remain_d;
      pos_q    <= pos_d;
      sum_q    <= sum_d;
      add_q    <= add_d;
      addr_q   <= addr_d;
      cmd_q    <= cmd_d;
      len_q    <= len_d;
      sumrx_q  <= sumrx_d;
    end
  end

  // next state and token
  always_comb begin
    phase_d  = phase_q;
    remain_d = remain_q;
    pos_d    = pos_q;
    sum_d    = sum_q;
    add_d    = add_q;
    addr_d   = addr_q;
    cmd_d    = cmd_q;
    len_d    = len_q;
    sumrx_d  = sumrx_q;

    tok_valid_o    = 1'b0;
    tok_o.kind     = KIND_PAYLOAD;
    tok_o.data     = rx_byte_i;
    tok_o.index    = pos_q;
    tok_o.addr     = addr_q;
    tok_o.cmd      = cmd_q;
    tok_o.len      = len_q;
    tok_o.sum_calc = sum_q;
    tok_o.sum_rx   = sumrx_q;
    tok_o.add_calc = add_q;

    if (byte_valid_i) begin
      unique case (phase_q)
        PH_ADDR: begin
          if (rx_byte_i == own_q || rx_byte_i == bcast_q) begin
            addr_d  = rx_byte_i;
            sum_d   = sum_acc;
            add_d   = add_acc;
            phase_d = PH_CMD;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_CMD: begin
          cmd_d   = rx_byte_i;
          sum_d   = sum_acc;
          add_d   = add_acc;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          if (rx_byte_i < LengthLimit) begin
            len_d    = rx_byte_i;
            remain_d = rx_byte_i;
            pos_d    = '0;
            sum_d    = sum_acc;
            add_d    = add_acc;
            phase_d  = PH_PAYLOAD;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          // zero-length frame: the byte is swallowed and the frame dropped
          if (remain_q != 8'd0) begin
            tok_valid_o = 1'b1;
            sum_d    = sum_acc;
            add_d    = add_acc;
            pos_d    = pos_q + 8'd1;
            remain_d = remain_q - 8'd1;
            phase_d  = (remain_q == 8'd1) ? PH_SUMCHK : PH_PAYLOAD;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_SUMCHK: begin
          sumrx_d = rx_byte_i;
          phase_d = PH_ADDCHK;
        end
        PH_ADDCHK: begin
          tok_valid_o = 1'b1;
          tok_o.kind  = KIND_END;
          phase_d     = PH_HUNT;
        end
        default: begin
          // hunting, and the unused phase code
          if (rx_byte_i == HeaderByte) begin
            sum_d   = rx_byte_i;
            add_d   = rx_byte_i;
            phase_d = PH_ADDR;
          end else begin
            phase_d = PH_HUNT;
          end
        end
      endcase
    end
  end

endmodule

/* src/fpp_fifo.sv */
// short token queue between the parser and the output stage
// depends on fpp_pkg
`timescale 1ns / 1ps

module fpp_fifo
  import fpp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_en_i,
  input  tok_t   wr_data_i,
  input  logic   rd_en_i,
  output tok_t   rd_data_o,
  output qstat_t stat_o
);

  tok_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_wr        = wr_en_i && !stat_o.full;
  assign do_rd        = rd_en_i && !stat_o.empty;
  assign rd_data_o    = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: ;
      endcase
    end
  end

endmodule

/* src/fpp_back.sv */
// back end: frame check compare and result output register
// depends on fpp_pkg
`timescale 1ns / 1ps

module fpp_back
  import fpp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tok_t       tok_i,
  input  qstat_t     qstat_i,
  output logic       tok_rd_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic       result_kind_o,
  output logic [7:0] payload_byte_o,
  output logic [7:0] payload_index_o,
  output logic [7:0] frame_address_o,
  output logic [7:0] frame_command_o,
  output logic [7:0] frame_length_o,
  output logic [1:0] frame_status_o
);

  logic       out_valid_q;
  logic       load;
  status_e    status;
  kind_e      kind_q;
  logic [7:0] byte_q, index_q, addr_q, cmd_q, len_q;
  status_e    status_q;

  // take the next token when the output register is free or being drained
  assign load     = !qstat_i.empty && (!out_valid_q || pop_i);
  assign tok_rd_o = load;

  // frame check: sum check is tested first
  always_comb begin
    status = ST_OK;
    if (tok_i.kind == KIND_END) begin
      if (tok_i.sum_calc != tok_i.sum_rx) begin
        status = ST_SUM_ERR;
      end else if (tok_i.add_calc != tok_i.data) begin
        status = ST_ADD_ERR;
      end
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= tok_i.kind;
      byte_q   <= (tok_i.kind == KIND_END) ? 8'd0 : tok_i.data;
      index_q  <= (tok_i.kind == KIND_END) ? 8'd0 : tok_i.index;
      addr_q   <= tok_i.addr;
      cmd_q    <= tok_i.cmd;
      len_q    <= tok_i.len;
      status_q <= status;
    end
  end

  assign empty_o         = !out_valid_q;
  assign result_kind_o   = kind_q;
  assign payload_byte_o  = byte_q;
  assign payload_index_o = index_q;
  assign frame_address_o = addr_q;
  assign frame_command_o = cmd_q;
  assign frame_length_o  = len_q;
  assign frame_status_o  = status_q;

endmodule

/* src/framed_packet_parser_sum_add_check.sv */
// channel   | handshake              | payload
// ----------+------------------------+----------------------------------------
// input     | push / full            | rx_byte_i
// result    | empty / pop            | result_kind_o .. frame_status_o
// config    | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// one received byte is taken every clock while full is low; a result reaches the
// result ports through a four-entry token queue and an output register. full
// rises only when the queue holds four results and the output register is
// occupied. reset (rst_ni low, asynchronous) returns the parser to header
// hunting and the addresses to 0x11 and 0xFF. config writes are always ready.
//
// top level of the framed packet parser; instantiates fpp_front, fpp_fifo
// and fpp_back, depends on fpp_pkg
`timescale 1ns / 1ps

module framed_packet_parser_sum_add_check
  import fpp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic               result_kind_o,
  output logic [7:0]         payload_byte_o,
  output logic [7:0]         payload_index_o,
  output logic [7:0]         frame_address_o,
  output logic [7:0]         frame_command_o,
  output logic [7:0]         frame_length_o,
  output logic [1:0]         frame_status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  logic   byte_acc;
  logic   tok_valid;
  tok_t   tok_wr, tok_rd;
  logic   tok_pop;
  qstat_t qstat;

  assign cfg_ready_o = 1'b1;
  assign full        = qstat.full;
  assign byte_acc    = push && !qstat.full;

  // parser
  fpp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .byte_valid_i (byte_acc),
    .rx_byte_i    (rx_byte_i),
    .tok_valid_o  (tok_valid),
    .tok_o        (tok_wr)
  );

  // token queue
  fpp_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (tok_valid),
    .wr_data_i (tok_wr),
    .rd_en_i   (tok_pop),
    .rd_data_o (tok_rd),
    .stat_o    (qstat)
  );

  // check and output register
  fpp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tok_i           (tok_rd),
    .qstat_i         (qstat),
    .tok_rd_o        (tok_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .result_kind_o   (result_kind_o),
    .payload_byte_o  (payload_byte_o),
    .payload_index_o (payload_index_o),
    .frame_address_o (frame_address_o),
    .frame_command_o (frame_command_o),
    .frame_length_o  (frame_length_o),
    .frame_status_o  (frame_status_o)
  );

endmodule

/* src/fpp_checker.sv */
// port-level checker for the framed packet parser, bound to the top level
// depends on fpp_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "framed_packet_parser_sum_add_check_defines.svh"

module fpp_checker
  import fpp_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic [7:0]         rx_byte_i,
  input logic               empty,
  input logic               pop,
  input logic               result_kind_o,
  input logic [7:0]         payload_byte_o,
  input logic [7:0]         payload_index_o,
  input logic [7:0]         frame_address_o,
  input logic [7:0]         frame_command_o,
  input logic [7:0]         frame_length_o,
  input logic [1:0]         frame_status_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [CfgIdxW-1:0] cfg_index_i,
  input logic [7:0]         cfg_data_i
);

  // payload transactions carry an ok status
  `FPP_ASSERT_NOW(a_payload_status, !empty && result_kind_o == KIND_PAYLOAD, frame_status_o == ST_OK, "payload result with nonzero status")

  // frame end transactions carry zero payload fields
  `FPP_ASSERT_NOW(a_end_fields, !empty && result_kind_o == KIND_END, payload_byte_o == 8'd0 && payload_index_o == 8'd0, "frame end with payload fields set")

  // payload index stays inside the frame length
  `FPP_ASSERT_NOW(a_index_range, !empty && result_kind_o == KIND_PAYLOAD, payload_index_o < frame_length_o, "payload index beyond frame length")

  // a waiting result is not withdrawn
  `FPP_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty, "result dropped before pop")

endmodule

bind framed_packet_parser_sum_add_check fpp_checker u_fpp_checker (.*);

/* bench/fpp_result_checker.sv */
// result checker for the framed packet parser: tracks accepted bytes and config
// writes, predicts each result and compares the popped ones; depends on fpp_pkg
`timescale 1ns / 1ps

module fpp_result_checker
  import fpp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  logic               result_kind_i,
  input  logic [7:0]         payload_byte_i,
  input  logic [7:0]         payload_index_i,
  input  logic [7:0]         frame_address_i,
  input  logic [7:0]         frame_command_i,
  input  logic [7:0]         frame_length_i,
  input  logic [1:0]         frame_status_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  output int                 error_count_o,
  output int                 pending_count_o
);

  typedef struct {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] index;
    logic [7:0] addr;
    logic [7:0] cmd;
    logic [7:0] len;
    status_e    status;
  } frame_item_t;

  // results the parser owes, oldest first
  frame_item_t items_due[$];

  // own copy of the address registers and the parser state
  logic [7:0] own_addr;
  logic [7:0] bcast_addr;
  phase_e     phase;
  logic [7:0] left_cnt;
  logic [7:0] pos_cnt;
  logic [7:0] sum_acc;
  logic [7:0] add_acc;
  logic [7:0] addr_q;
  logic [7:0] cmd_q;
  logic [7:0] len_q;
  logic [7:0] sum_rx;

  // running sum, then running sum of sums
  task automatic fold_in(input logic [7:0] b);
    sum_acc = sum_acc + b;
    add_acc = add_acc + sum_acc;
  endtask

  task automatic owe_item(input kind_e kind, input logic [7:0] data,
                          input logic [7:0] index, input status_e status);
    frame_item_t it;
    it.kind   = kind;
    it.data   = data;
    it.index  = index;
    it.addr   = addr_q;
    it.cmd    = cmd_q;
    it.len    = len_q;
    it.status = status;
    items_due.push_back(it);
  endtask

  // one received byte through the frame parser
  task automatic parse_byte(input logic [7:0] b);
    status_e st;
    case (phase)
      PH_ADDR: begin
        if (b == own_addr || b == bcast_addr) begin
          addr_q = b;
          fold_in(b);
          phase = PH_CMD;
        end else begin
          phase = PH_HUNT;
        end
      end
      PH_CMD: begin
        cmd_q = b;
        fold_in(b);
        phase = PH_LEN;
      end
      PH_LEN: begin
        if (b < LengthLimit) begin
          len_q    = b;
          left_cnt = b;
          pos_cnt  = 8'd0;
          fold_in(b);
          phase = PH_PAYLOAD;
        end else begin
          phase = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        // zero length: this byte is swallowed and the frame dropped
        if (left_cnt != 8'd0) begin
          fold_in(b);
          owe_item(KIND_PAYLOAD, b, pos_cnt, ST_OK);
          pos_cnt  = pos_cnt + 8'd1;
          left_cnt = left_cnt - 8'd1;
          phase = (left_cnt == 8'd0) ? PH_SUMCHK : PH_PAYLOAD;
        end else begin
          phase = PH_HUNT;
        end
      end
      PH_SUMCHK: begin
        sum_rx = b;
        phase = PH_ADDCHK;
      end
      PH_ADDCHK: begin
        // sum check wins when both are wrong
        if (sum_acc != sum_rx) st = ST_SUM_ERR;
        else if (add_acc != b) st = ST_ADD_ERR;
        else st = ST_OK;
        owe_item(KIND_END, 8'd0, 8'd0, st);
        phase = PH_HUNT;
      end
      default: begin
        if (b == HeaderByte) begin
          sum_acc = 8'd0;
          add_acc = 8'd0;
          fold_in(b);
          phase = PH_ADDR;
        end else begin
          phase = PH_HUNT;
        end
      end
    endcase
  endtask

  // compare one popped result with the oldest owed one
  task automatic check_popped();
    frame_item_t it;
    if (items_due.size() == 0) begin
      error_count_o = error_count_o + 1;
      if (error_count_o <= 10)
        $display("%0t: unexpected result kind %0d byte %0d index %0d status %0d",
                 $realtime, result_kind_i, payload_byte_i, payload_index_i,
                 frame_status_i);
    end else begin
      it = items_due.pop_front();
      if (result_kind_i !== it.kind || payload_byte_i !== it.data ||
          payload_index_i !== it.index || frame_address_i !== it.addr ||
          frame_command_i !== it.cmd || frame_length_i !== it.len ||
          frame_status_i !== it.status) begin
        error_count_o = error_count_o + 1;
        if (error_count_o <= 10) begin
          $display("%0t: mismatch, expected kind %0d byte %0d index %0d addr %0d cmd %0d len %0d status %0d",
                   $realtime, it.kind, it.data, it.index, it.addr, it.cmd, it.len,
                   it.status);
          $display("%0t:           actual kind %0d byte %0d index %0d addr %0d cmd %0d len %0d status %0d",
                   $realtime, result_kind_i, payload_byte_i, payload_index_i,
                   frame_address_i, frame_command_i, frame_length_i, frame_status_i);
        end
      end
    end
  endtask

  // watch all three channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr   = OwnAddrRst;
      bcast_addr = BcastAddrRst;
      phase      = PH_HUNT;
      left_cnt   = 8'd0;
      pos_cnt    = 8'd0;
      sum_acc    = 8'd0;
      add_acc    = 8'd0;
      addr_q     = 8'd0;
      cmd_q      = 8'd0;
      len_q      = 8'd0;
      sum_rx     = 8'd0;
      error_count_o = 0;
      items_due.delete();
    end else begin
      if (pop_i && !empty_i) check_popped();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_OWN_ADDR:   own_addr = cfg_data_i;
          CFG_BCAST_ADDR: bcast_addr = cfg_data_i;
          default: ;
        endcase
      end
      if (push_i && !full_i) parse_byte(rx_byte_i);
    end
    pending_count_o = items_due.size();
  end

endmodule

/* bench/tb_framed_packet_parser_sum_add_check.sv */
// testbench top for the framed packet parser: clock, reset, byte and config
// stimulus, result back-pressure and verdict; uses fpp_pkg and fpp_result_checker
`timescale 1ns / 1ps

module tb_framed_packet_parser_sum_add_check;
  import fpp_pkg::*;

  localparam int IdleLimit = 4000;

  typedef enum int {
    FR_GOOD,
    FR_BAD_SUM,
    FR_BAD_ADD,
    FR_BAD_BOTH,
    FR_CUT,
    FR_ZERO_LEN,
    FR_LONG_LEN,
    FR_BAD_ADDR
  } frame_form_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] rx_byte = 8'd0;
  logic       empty;
  logic       pop = 1'b0;
  logic       result_kind;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [7:0] frame_address;
  logic [7:0] frame_command;
  logic [7:0] frame_length;
  logic [1:0] frame_status;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_idx_e   cfg_index = CFG_OWN_ADDR;
  logic [7:0] cfg_data = 8'd0;

  int error_count;
  int pending_count;

  // stimulus state
  logic [7:0] tx_bytes[$];
  logic [7:0] cur_own = OwnAddrRst;
  logic [7:0] cur_bcast = BcastAddrRst;
  int         bytes_sent = 0;
  bit         tx_gaps_on = 1'b1;
  bit         rx_gaps_on = 1'b1;
  int         hold_req = 0;
  bit         max_len_done = 1'b0;
  int         idle_cycles = 0;

  always #4 clk_i = ~clk_i;

  framed_packet_parser_sum_add_check DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .rx_byte_i       (rx_byte),
    .empty           (empty),
    .pop             (pop),
    .result_kind_o   (result_kind),
    .payload_byte_o  (payload_byte),
    .payload_index_o (payload_index),
    .frame_address_o (frame_address),
    .frame_command_o (frame_command),
    .frame_length_o  (frame_length),
    .frame_status_o  (frame_status),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  fpp_result_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_i          (full),
    .rx_byte_i       (rx_byte),
    .empty_i         (empty),
    .pop_i           (pop),
    .result_kind_i   (result_kind),
    .payload_byte_i  (payload_byte),
    .payload_index_i (payload_index),
    .frame_address_i (frame_address),
    .frame_command_i (frame_command),
    .frame_length_i  (frame_length),
    .frame_status_i  (frame_status),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .error_count_o   (error_count),
    .pending_count_o (pending_count)
  );

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("** framed_packet_parser_sum_add_check: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side: random pop gaps, plus long hold-offs on request
  initial begin
    int hold_left;
    int r;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left = hold_left - 1;
      end else if (hold_req > 0) begin
        pop <= 1'b0;
        hold_left = hold_req - 1;
        hold_req = 0;
      end else begin
        r = $urandom_range(0, 99);
        if (rx_gaps_on && r < 25) begin
          pop <= 1'b0;
          hold_left = (r < 2) ? $urandom_range(10, 50) : $urandom_range(0, 2);
        end else begin
          pop <= 1'b1;
        end
      end
    end
  end

  // offer one byte and hold it until it is taken
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    push <= 1'b1;
    rx_byte <= b;
    do @(posedge clk_i); while (full);
    bytes_sent = bytes_sent + 1;
  endtask

  task automatic tx_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = 0;
    if (tx_gaps_on && r >= 65) n = (r >= 97) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    repeat (n) @(negedge clk_i) push <= 1'b0;
  endtask

  task automatic send_queued();
    foreach (tx_bytes[i]) begin
      tx_gap();
      send_byte(tx_bytes[i]);
    end
  endtask

  // header, address, command, length, payload, then the two check bytes
  task automatic build_frame(input logic [7:0] addr, input logic [7:0] cmd,
                             input int len, input frame_form_e form);
    logic [7:0] s;
    logic [7:0] a;
    logic [7:0] sum_b;
    logic [7:0] add_b;
    int         n_pay;
    int         keep;
    tx_bytes.delete();
    tx_bytes.push_back(HeaderByte);
    tx_bytes.push_back(addr);
    tx_bytes.push_back(cmd);
    tx_bytes.push_back(len[7:0]);
    n_pay = (form == FR_LONG_LEN) ? 3 : len;
    repeat (n_pay) tx_bytes.push_back(8'($urandom_range(0, 255)));
    s = 8'd0;
    a = 8'd0;
    foreach (tx_bytes[i]) begin
      s = s + tx_bytes[i];
      a = a + s;
    end
    sum_b = s;
    add_b = a;
    if (form == FR_BAD_SUM || form == FR_BAD_BOTH) sum_b = s ^ 8'($urandom_range(1, 255));
    if (form == FR_BAD_ADD || form == FR_BAD_BOTH) add_b = a ^ 8'($urandom_range(1, 255));
    tx_bytes.push_back(sum_b);
    tx_bytes.push_back(add_b);
    // broken sequence: frame ends early, the next frame runs into it
    if (form == FR_CUT) begin
      keep = $urandom_range(1, tx_bytes.size() - 1);
      while (tx_bytes.size() > keep) void'(tx_bytes.pop_back());
    end
  endtask

  task automatic random_frame();
    int          r;
    int          len;
    logic [7:0]  addr;
    logic [7:0]  cmd;
    frame_form_e form;
    tx_gaps_on = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 9) == 0) rx_gaps_on = !rx_gaps_on;
    r = $urandom_range(0, 99);
    // line noise with a few stray headers
    if (r >= 93) begin
      tx_bytes.delete();
      repeat ($urandom_range(1, 6))
        tx_bytes.push_back(($urandom_range(0, 3) == 0) ? HeaderByte
                                                       : 8'($urandom_range(0, 255)));
      send_queued();
      return;
    end
    if (r < 55) form = FR_GOOD;
    else if (r < 63) form = FR_BAD_SUM;
    else if (r < 70) form = FR_BAD_ADD;
    else if (r < 74) form = FR_BAD_BOTH;
    else if (r < 80) form = FR_CUT;
    else if (r < 84) form = FR_ZERO_LEN;
    else if (r < 88) form = FR_LONG_LEN;
    else form = FR_BAD_ADDR;
    r = $urandom_range(0, 99);
    if (r < 90) len = $urandom_range(1, 12);
    else if (r < 98) len = $urandom_range(13, 64);
    else len = $urandom_range(65, 249);
    if (form == FR_GOOD && !max_len_done) begin
      len = 249;
      max_len_done = 1'b1;
    end
    if (form == FR_ZERO_LEN) len = 0;
    if (form == FR_LONG_LEN) len = $urandom_range(250, 255);
    addr = ($urandom_range(0, 99) < 55) ? cur_own : cur_bcast;
    if (form == FR_BAD_ADDR) begin
      do addr = 8'($urandom_range(0, 255)); while (addr == cur_own || addr == cur_bcast);
    end
    cmd = 8'($urandom_range(0, 255));
    build_frame(addr, cmd, len, form);
    send_queued();
  endtask

  task automatic run_random(input int target);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < target) random_frame();
  endtask

  // pause the input until every owed result has been popped
  task automatic drain();
    @(negedge clk_i) push <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] val);
    drain();
    // frames that end without a result may still be inside the block
    repeat (6) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i) cfg_valid <= 1'b0;
    case (idx)
      CFG_OWN_ADDR:   cur_own = val;
      CFG_BCAST_ADDR: cur_bcast = val;
      default: ;
    endcase
  endtask

  // result side stalls long while payload bytes keep coming
  task automatic fill_and_stall();
    tx_gaps_on = 1'b0;
    hold_req = 300;
    repeat (6) begin
      build_frame(cur_own, 8'($urandom_range(0, 255)), $urandom_range(8, 16), FR_GOOD);
      send_queued();
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: noise, minimal good frame, zero length, bad address,
    // length at the limit, both checks wrong
    tx_bytes = '{8'h00, 8'hFF};
    send_queued();
    build_frame(OwnAddrRst, 8'h00, 1, FR_GOOD);
    send_queued();
    build_frame(BcastAddrRst, 8'hFF, 0, FR_ZERO_LEN);
    send_queued();
    tx_bytes = '{HeaderByte, 8'h12, HeaderByte, OwnAddrRst, 8'h05, LengthLimit};
    send_queued();
    build_frame(OwnAddrRst, 8'h01, 1, FR_BAD_BOTH);
    send_queued();

    // random frames under several address settings
    run_random(230);
    write_reg(CFG_OWN_ADDR, 8'h00);
    write_reg(CFG_BCAST_ADDR, 8'hFF);
    fill_and_stall();
    run_random(230);
    write_reg(CFG_OWN_ADDR, 8'hFF);
    write_reg(CFG_BCAST_ADDR, 8'h00);
    run_random(115);
    drain();
    run_random(115);
    write_reg(CFG_OWN_ADDR, HeaderByte);
    write_reg(CFG_BCAST_ADDR, HeaderByte);
    run_random(230);
    write_reg(CFG_OWN_ADDR, 8'($urandom_range(0, 255)));
    write_reg(CFG_BCAST_ADDR, 8'($urandom_range(0, 255)));
    run_random(230);
    write_reg(CFG_BCAST_ADDR, 8'($urandom_range(0, 255)));
    run_random(230);

    drain();
    repeat (20) @(negedge clk_i);
    if (error_count == 0 && pending_count == 0)
      $display("** framed_packet_parser_sum_add_check: PASSED **");
    else
      $display("** framed_packet_parser_sum_add_check: FAILED **");
    $finish;
  end

endmodule
